// ----- hdl/rational_arithmetic_unit_top_macros.svh -----
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAU_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT(label, clk, rst_n, prop, msg)
`define RAU_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- hdl/rau_pkg.sv -----
// Package for the rational arithmetic unit: codes, widths and shared types.
`default_nettype none
package rau_pkg;
  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int MAG_W = 64;

  localparam logic [2:0] ACT_REDUCE = 3'd0;
  localparam logic [2:0] ACT_CMP    = 3'd1;
  localparam logic [2:0] ACT_ADD    = 3'd2;
  localparam logic [2:0] ACT_SUB    = 3'd3;
  localparam logic [2:0] ACT_MUL    = 3'd4;
  localparam logic [2:0] ACT_DIV    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_DIVZERO  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // shared unit opcodes
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV
  } op_t;

  // request to the shared unit
  typedef struct packed {
    logic             start;
    op_t              op;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } unit_req_t;

  // response from the shared unit
  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quo;
    logic [MAG_W-1:0] rem;
  } unit_rsp_t;
endpackage
`default_nettype wire

// ----- hdl/rau_unit.sv -----
// Shared shift-add multiplier and restoring divider, one bit a cycle.
`default_nettype none
`include "rational_arithmetic_unit_top_macros.svh"
module rau_unit
  import rau_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire unit_req_t req,
  output unit_rsp_t rsp
);
  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             busy_r, busy_nxt;
  op_t              op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] acc_r, acc_nxt;   // product or remainder
  logic [MAG_W-1:0] sh_r, sh_nxt;     // multiplicand or dividend/quotient
  logic [MAG_W-1:0] opb_r, opb_nxt;   // multiplier or divisor
  logic             done_r, done_nxt;
  logic [MAG_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    opb_nxt  = opb_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (!busy_r && req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = CNT_W'(MAG_W);
      acc_nxt  = '0;
      sh_nxt   = req.a;
      opb_nxt  = req.b;
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        // multiplier bits consumed LSB first
        if (opb_r[0]) acc_nxt = acc_r + sh_r;
        sh_nxt  = {sh_r[MAG_W-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[MAG_W-1:1]};
      end else begin
        trial = {acc_r, sh_r[MAG_W-1]} - {1'b0, opb_r};
        if (!trial[MAG_W]) begin
          acc_nxt = trial[MAG_W-1:0];
          sh_nxt  = {sh_r[MAG_W-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[MAG_W-2:0], sh_r[MAG_W-1]};
          sh_nxt  = {sh_r[MAG_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    opb_r <= opb_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = (op_r == OP_MUL) ? acc_r : sh_r;
  assign rsp.rem  = acc_r;

  `RAU_ASSERT(a_done_after_busy, clk, rst_n, rsp.done |-> $past(busy_r), "done without busy")
  `RAU_ASSERT(a_cnt_zero_idle, clk, rst_n, !busy_r |-> cnt_r == '0 || rsp.done || !$past(busy_r), "counter left running")
  `RAU_ASSERT(a_no_start_busy, clk, rst_n, busy_r && !$past(busy_r) |-> $past(req.start), "busy without start")
endmodule
`default_nettype wire

// ----- hdl/rau_seq.sv -----
// Sequencer: walks each action through the shared multiply/divide unit.
`default_nettype none
`include "rational_arithmetic_unit_top_macros.svh"
module rau_seq
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               in_action,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_num_a,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_den_a,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_num_b,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_den_b,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    out_status,
  output logic signed [1:0]             out_order,
  output logic signed [63:0]            out_result_num,
  output logic [62:0]                   out_result_den,
  output unit_req_t                     req,
  input  wire unit_rsp_t                rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_M1, S_M2, S_ADDG, S_LCM1, S_LCM2, S_LCM3,
    S_COMB, S_GCD, S_RN, S_RD, S_WAIT, S_OUT
  } state_t;

  state_t           state_r, ret_r;
  logic [2:0]       act_r;
  logic [MAG_W-1:0] na_r, da_r, nb_r, db_r;
  logic             sa_r, sb_r;
  logic [MAG_W-1:0] x_r, y_r;      // working numerator / denominator magnitudes
  logic [MAG_W-1:0] ga_r, gb_r;    // Euclid pair
  logic             neg_r;
  logic             ustart_r;
  op_t              uop_r;
  logic [MAG_W-1:0] ua_r, ub_r;
  logic             ovalid_r;
  logic [1:0]       ost_r;
  logic signed [1:0] oord_r;
  logic [63:0]      onum_r;
  logic [62:0]      oden_r;
  logic             gcd_for_lcm_r;

  function automatic logic [MAG_W:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
    logic [MAG_W-1:0] e;
    e = MAG_W'($unsigned(v));
    if (v[OPERAND_WIDTH-1]) e = MAG_W'($unsigned(-v)) & ((MAG_W'(1) << OPERAND_WIDTH) - 1);
    return {v[OPERAND_WIDTH-1], e};
  endfunction

  logic [MAG_W:0] ma, mda, mb, mdb;
  assign ma  = mag_of(in_num_a);
  assign mda = mag_of(in_den_a);
  assign mb  = mag_of(in_num_b);
  assign mdb = mag_of(in_den_b);

  assign in_ready = (state_r == S_IDLE);
  assign req = '{start: ustart_r, op: uop_r, a: ua_r, b: ub_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      ovalid_r <= 1'b0;
      ustart_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r <= in_action;
            na_r <= ma[MAG_W-1:0];  da_r <= mda[MAG_W-1:0];
            nb_r <= mb[MAG_W-1:0];  db_r <= mdb[MAG_W-1:0];
            sa_r <= ma[MAG_W] ^ mda[MAG_W];
            sb_r <= mb[MAG_W] ^ mdb[MAG_W];
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          oord_r <= 2'sd0; onum_r <= '0; oden_r <= '0;
          if (act_r > ACT_DIV || da_r == '0 || (act_r != ACT_REDUCE && db_r == '0)) begin
            ost_r <= ST_INVALID; state_r <= S_OUT;
          end else if (act_r == ACT_DIV && nb_r == '0) begin
            ost_r <= ST_DIVZERO; state_r <= S_OUT;
          end else begin
            ost_r <= ST_OK;
            case (act_r)
              ACT_REDUCE: begin
                x_r <= na_r; y_r <= da_r; neg_r <= sa_r;
                ga_r <= na_r; gb_r <= da_r; gcd_for_lcm_r <= 1'b0;
                state_r <= S_GCD;
              end
              ACT_ADD, ACT_SUB: begin
                ga_r <= da_r; gb_r <= db_r; gcd_for_lcm_r <= 1'b1;
                state_r <= S_GCD;
              end
              default: begin
                // first product: cross or straight
                uop_r <= OP_MUL; ustart_r <= 1'b1;
                ua_r <= na_r;
                ub_r <= (act_r == ACT_MUL) ? nb_r : db_r;
                ret_r <= S_M1; state_r <= S_WAIT;
              end
            endcase
          end
        end
        S_M1: begin
          // second product: nb*da for compare, da*db for multiply, da*nb for divide
          x_r <= rsp.quo;
          uop_r <= OP_MUL; ustart_r <= 1'b1;
          ua_r <= (act_r == ACT_CMP) ? nb_r : da_r;
          ub_r <= (act_r == ACT_MUL) ? db_r : (act_r == ACT_CMP) ? da_r : nb_r;
          ret_r <= S_M2; state_r <= S_WAIT;
        end
        S_M2: begin
          if (act_r == ACT_CMP) begin
            // signed compare of x (sign sa) with product (sign sb)
            logic xn, yn;
            xn = sa_r && x_r != '0;
            yn = sb_r && rsp.quo != '0;
            if (xn != yn) oord_r <= xn ? -2'sd1 : 2'sd1;
            else if (x_r == rsp.quo) oord_r <= 2'sd0;
            else if (x_r < rsp.quo) oord_r <= xn ? 2'sd1 : -2'sd1;
            else oord_r <= xn ? -2'sd1 : 2'sd1;
            state_r <= S_OUT;
          end else begin
            y_r <= rsp.quo; neg_r <= sa_r ^ sb_r;
            ga_r <= x_r; gb_r <= rsp.quo; gcd_for_lcm_r <= 1'b0;
            state_r <= S_GCD;
          end
        end
        // Euclid: one modulo on the shared unit per step
        S_GCD: begin
          if (gb_r == '0) begin
            if (gcd_for_lcm_r) state_r <= S_LCM1;
            else begin
              uop_r <= OP_DIV; ustart_r <= 1'b1; ua_r <= x_r; ub_r <= ga_r;
              ret_r <= S_RN; state_r <= S_WAIT;
            end
          end else begin
            uop_r <= OP_DIV; ustart_r <= 1'b1; ua_r <= ga_r; ub_r <= gb_r;
            ret_r <= S_ADDG; state_r <= S_WAIT;
          end
        end
        S_ADDG: begin
          ga_r <= gb_r; gb_r <= rsp.rem; state_r <= S_GCD;
        end
        S_LCM1: begin
          // fa = db/g -> x
          uop_r <= OP_DIV; ustart_r <= 1'b1; ua_r <= db_r; ub_r <= ga_r;
          ret_r <= S_LCM2; state_r <= S_WAIT;
        end
        S_LCM2: begin
          x_r <= rsp.quo;
          uop_r <= OP_DIV; ustart_r <= 1'b1; ua_r <= da_r; ub_r <= ga_r;
          ret_r <= S_LCM3; state_r <= S_WAIT;
        end
        S_LCM3: begin
          // fb -> y; ta = na*fa next
          y_r <= rsp.quo;
          uop_r <= OP_MUL; ustart_r <= 1'b1; ua_r <= na_r; ub_r <= x_r;
          ret_r <= S_COMB; state_r <= S_WAIT; ga_r <= '0; gb_r <= '0;
        end
        S_COMB: begin
          // staged: ga=0 -> store ta, mult tb; gb flags tb ready; then lcm
          if (ga_r == '0 && gb_r == '0) begin
            ga_r <= rsp.quo | {{(MAG_W-1){1'b0}}, 1'b0}; gb_r <= '1;
            x_r  <= rsp.quo;
            uop_r <= OP_MUL; ustart_r <= 1'b1; ua_r <= nb_r; ub_r <= y_r;
            ret_r <= S_COMB; state_r <= S_WAIT;
          end else if (gb_r == '1) begin
            logic s2;
            s2 = (act_r == ACT_SUB) ? !sb_r : sb_r;
            if (sa_r == s2) begin x_r <= x_r + rsp.quo; neg_r <= sa_r; end
            else if (x_r >= rsp.quo) begin x_r <= x_r - rsp.quo; neg_r <= sa_r; end
            else begin x_r <= rsp.quo - x_r; neg_r <= s2; end
            gb_r <= {{(MAG_W-1){1'b0}}, 1'b1} << 1;
            uop_r <= OP_MUL; ustart_r <= 1'b1; ua_r <= y_r; ub_r <= db_r;
            ret_r <= S_COMB; state_r <= S_WAIT;
          end else begin
            y_r <= rsp.quo;
            ga_r <= x_r; gb_r <= rsp.quo; gcd_for_lcm_r <= 1'b0;
            state_r <= S_GCD;
          end
        end
        S_RN: begin
          x_r <= rsp.quo;
          uop_r <= OP_DIV; ustart_r <= 1'b1; ua_r <= y_r; ub_r <= ga_r;
          ret_r <= S_RD; state_r <= S_WAIT;
        end
        S_RD: begin
          if ((x_r != '0 && neg_r && x_r > 64'h8000_0000_0000_0000) ||
              (!(neg_r && x_r != '0) && x_r > 64'h7FFF_FFFF_FFFF_FFFF)) begin
            ost_r <= ST_OVERFLOW;
          end else begin
            onum_r <= (neg_r && x_r != '0) ? (~x_r + 64'd1) : x_r;
            oden_r <= rsp.quo[62:0];
          end
          state_r <= S_OUT;
        end
        S_WAIT: begin
          // start is a one-cycle pulse on entry
          ustart_r <= 1'b0;
          if (rsp.done) state_r <= ret_r;
        end
        S_OUT: begin
          if (!ovalid_r) ovalid_r <= 1'b1;
          else if (out_ready) begin
            ovalid_r <= 1'b0; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = ovalid_r;
  assign out_status     = ost_r;
  assign out_order      = oord_r;
  assign out_result_num = onum_r;
  assign out_result_den = oden_r;

  `RAU_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> !out_valid, "ready while result pending")
  `RAU_ASSERT(a_out_ok_den, clk, rst_n, out_valid && out_status != ST_OK |-> out_result_den == '0 && out_order == 2'sd0, "error result carries data")
  `RAU_ASSERT(a_start_idle, clk, rst_n, req.start |=> state_r == S_WAIT, "unit started outside wait")
endmodule
`default_nettype wire

// ----- hdl/rational_arithmetic_unit_top.sv -----
// Top level of the rational arithmetic unit.
// One item at a time: an item is taken when in_ready is high, and its result follows after
// a sequence of uses of the shared 64-bit shift-add multiplier / restoring divider:
// compare takes 2 uses, reduce runs the Euclid steps plus 2 divisions, multiply and
// divide 2 products plus Euclid steps plus 2 divisions, add and subtract add a second
// Euclid pass. Invalid and divide-by-zero items skip the shared unit. in_ready stays low
// until the result has been taken.
`default_nettype none
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [2:0] in_action,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_num_a,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_den_a,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_num_b,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_den_b,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [1:0] out_status,
  output logic signed [1:0] out_order,
  output logic signed [63:0] out_result_num,
  output logic [62:0] out_result_den
);
  unit_req_t req;
  unit_rsp_t rsp;

  rau_seq #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_seq (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_num_a, .in_den_a,
    .in_num_b, .in_den_b, .out_valid, .out_ready, .out_status, .out_order,
    .out_result_num, .out_result_den, .req, .rsp
  );

  rau_unit u_unit (.clk, .rst_n, .req, .rsp);
endmodule
`default_nettype wire
